/* rtl/keyboard_dongle_serial_link_unit_assert.svh */
// Assertion macros shared by the keyboard dongle serial link RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef KEYBOARD_DONGLE_SERIAL_LINK_UNIT_ASSERT_SVH
`define KEYBOARD_DONGLE_SERIAL_LINK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define KDSL_ASSERT_IMPL(label, clk_s, rst_ns, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
        else $error("kdsl check failed");
// Next-cycle implication, checked outside reset.
`define KDSL_ASSERT_NEXT(label, clk_s, rst_ns, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
        else $error("kdsl check failed");
`else
`define KDSL_ASSERT_IMPL(label, clk_s, rst_ns, ante, cons)
`define KDSL_ASSERT_NEXT(label, clk_s, rst_ns, ante, cons)
`endif
`endif

/* rtl/kdsl_pkg.sv */
// Package for the keyboard dongle serial link: sizes, pin codes, types.
// No dependencies; imported by every module of the block but kdsl_ram.
package kdsl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int ROW_W       = ADDR_W - 1;
    localparam int BANK_DEPTH  = (QUEUE_DEPTH + 1) / 2;

    localparam logic [IDX_W-1:0] IDX_ZERO    = '0;
    localparam logic [IDX_W-1:0] ROOM_BREAK  = IDX_W'(QUEUE_DEPTH - 2);
    localparam logic [IDX_W-1:0] ROOM_POP    = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX   = IDX_W'(QUEUE_DEPTH);

    localparam logic [7:0] CODE_BREAK = 8'hF0;
    localparam logic [7:0] PIN_MASK   = 8'h0C;
    localparam logic [7:0] PINS_START = 8'h04;
    localparam logic [7:0] PINS_READY = 8'h08;
    localparam int         CLK_BIT    = 3;
    localparam int         LATCH_BIT  = 2;
    localparam int         DATA_BIT   = 1;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BIT_COUNT_ZERO = 4'd0;

    localparam int         CFG_IDX_W    = 1;
    localparam int         CFG_DATA_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE = 1'b1;

    typedef enum logic [1:0] {
        LINK_STOP  = 2'd0,
        LINK_START = 2'd1,
        LINK_READY = 2'd2
    } link_state_t;

    typedef struct packed {
        logic       valid;
        logic       release_key;
        logic       mapped;
        logic [7:0] code;
    } key_req_t;

    typedef struct packed {
        logic       empty;
        logic       can_pop;
        logic [7:0] head;
    } q_status_t;

endpackage

/* rtl/kdsl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the two banks of the scan code queue.
module kdsl_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/kdsl_queue.sv */
// Scan code queue: two interleaved RAM banks, write/read indices, forwarding.
// Depends on kdsl_pkg, kdsl_ram and the assertion header.
`include "keyboard_dongle_serial_link_unit_assert.svh"
module kdsl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  kdsl_pkg::key_req_t  key_req,
    input  logic                load_en,
    output kdsl_pkg::q_status_t status
);
    import kdsl_pkg::*;

    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [IDX_W-1:0]  ri_reg, ri_next;
    logic [IDX_W-1:0]  wi0, wi1, ri0, ri_inc;
    logic              empty, can_pop;
    logic              push_brk, push_code;

    logic [1:0]        we;
    logic [ROW_W-1:0]  waddr [2];
    logic [7:0]        wdata [2];
    logic [ROW_W-1:0]  raddr;
    logic [7:0]        rdata [2];

    logic [1:0]        fwd_hit_reg;
    logic [7:0]        fwd_data_reg [2];
    logic              sel_reg;
    logic [7:0]        bank_q [2];

    assign empty   = (wi_reg == ri_reg);
    assign can_pop = (wi_reg < ROOM_POP);
    assign ri_inc  = ri_reg + IDX_W'(1);

    // Key event: rewind an empty queue, then break prefix and code.
    always_comb
    begin
        wi0       = empty ? IDX_ZERO : wi_reg;
        ri0       = empty ? IDX_ZERO : ri_reg;
        push_brk  = key_req.release_key && (wi0 < ROOM_BREAK);
        wi1       = wi0 + IDX_W'(push_brk);
        push_code = key_req.mapped && (wi1 < DEPTH_IDX);
    end

    always_comb
    begin
        wi_next = wi_reg;
        ri_next = ri_reg;
        priority if (key_req.valid)
        begin
            wi_next = wi1 + IDX_W'(push_code);
            ri_next = ri0;
        end
        else if (load_en && !empty)
        begin
            if (can_pop && (wi_reg != ri_inc))
            begin
                ri_next = ri_inc;
            end
            else
            begin
                wi_next = IDX_ZERO;
                ri_next = IDX_ZERO;
            end
        end
    end

    // Consecutive addresses fall in opposite banks, so two pushes never collide.
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            we[b]    = 1'b0;
            waddr[b] = wi0[ADDR_W-1:1];
            wdata[b] = CODE_BREAK;
            if (key_req.valid && push_code && (wi1[0] == b[0]))
            begin
                we[b]    = 1'b1;
                waddr[b] = wi1[ADDR_W-1:1];
                wdata[b] = key_req.code;
            end
            else if (key_req.valid && push_brk && (wi0[0] == b[0]))
            begin
                we[b] = 1'b1;
            end
        end
    end

    assign raddr = ri_next[ADDR_W-1:1];

    for (genvar g = 0; g < 2; g++)
    begin : g_bank
        kdsl_ram #(
            .DEPTH (BANK_DEPTH),
            .WIDTH (8)
        ) u_ram (
            .clk   (clk),
            .we    (we[g]),
            .waddr (waddr[g]),
            .wdata (wdata[g]),
            .raddr (raddr),
            .rdata (rdata[g])
        );

        always_ff @(posedge clk)
        begin
            fwd_data_reg[g] <= wdata[g];
        end

        assign bank_q[g] = fwd_hit_reg[g] ? fwd_data_reg[g] : rdata[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg      <= IDX_ZERO;
            ri_reg      <= IDX_ZERO;
            sel_reg     <= 1'b0;
            fwd_hit_reg <= 2'b00;
        end
        else
        begin
            wi_reg         <= wi_next;
            ri_reg         <= ri_next;
            sel_reg        <= ri_next[0];
            fwd_hit_reg[0] <= we[0] && (waddr[0] == raddr);
            fwd_hit_reg[1] <= we[1] && (waddr[1] == raddr);
        end
    end

    assign status.empty   = empty;
    assign status.can_pop = can_pop;
    assign status.head    = sel_reg ? bank_q[1] : bank_q[0];

    `KDSL_ASSERT_IMPL(a_ri_le_wi, clk, rst_n, 1'b1, ri_reg <= wi_reg)
    `KDSL_ASSERT_IMPL(a_wi_bound, clk, rst_n, 1'b1, wi_reg <= DEPTH_IDX)
    `KDSL_ASSERT_IMPL(a_no_key_and_load, clk, rst_n, key_req.valid, !load_en)

endmodule

/* rtl/kdsl_link.sv */
// Link machine of the dongle: stop/start/ready states, bit counter, shifters.
// Depends on kdsl_pkg and the assertion header.
`include "keyboard_dongle_serial_link_unit_assert.svh"
module kdsl_link (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_en,
    input  logic                bypass,
    input  logic [7:0]          end_byte,
    input  logic [7:0]          port_prev,
    input  logic [7:0]          port_curr,
    input  kdsl_pkg::q_status_t q_status,
    output logic                load_en,
    output logic [7:0]          port_drive,
    output logic                enabled_next
);
    import kdsl_pkg::*;

    link_state_t state_reg, state_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_out_reg, shift_out_next;
    logic [7:0]  shift_in_reg, shift_in_next;
    logic        enabled_reg;

    logic        active, start_pins, ready_pins, falling, fall_ready;
    logic [7:0]  so_base, so_new, si_base;
    logic [3:0]  bc_dec;
    logic        end_hit;

    assign active     = sample_en && !bypass;
    assign start_pins = ((port_curr & PIN_MASK) == PINS_START);
    assign ready_pins = ((port_curr & PIN_MASK) == PINS_READY);
    assign falling    = port_prev[CLK_BIT] && !port_curr[CLK_BIT];
    assign fall_ready = active && (state_reg == LINK_READY) && falling;
    assign load_en    = fall_ready && (bit_count_reg == BITS_PER_BYTE);

    always_comb
    begin
        so_base = load_en ? 8'h00 : shift_out_reg;
        si_base = shift_in_reg;
        if (load_en)
        begin
            if (q_status.empty)
            begin
                si_base = 8'h00;
            end
            else if (q_status.can_pop)
            begin
                si_base = q_status.head;
            end
        end
        so_new  = {so_base[6:0], port_curr[LATCH_BIT]};
        bc_dec  = bit_count_reg - 4'd1;
        end_hit = (bc_dec == BIT_COUNT_ZERO) && (so_new == end_byte);
    end

    always_comb
    begin
        state_next = state_reg;
        if (active)
        begin
            unique case (state_reg)
                LINK_STOP:
                begin
                    if (start_pins)
                    begin
                        state_next = LINK_START;
                    end
                end
                LINK_START:
                begin
                    if (ready_pins)
                    begin
                        state_next = LINK_READY;
                    end
                end
                LINK_READY:
                begin
                    if (falling && end_hit)
                    begin
                        state_next = LINK_STOP;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        bit_count_next = bit_count_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        enabled_next   = enabled_reg;
        port_drive     = port_curr;
        if (active && (state_reg == LINK_STOP) && start_pins)
        begin
            enabled_next = 1'b1;
        end
        if (active && (state_reg == LINK_START) && ready_pins)
        begin
            bit_count_next = BITS_PER_BYTE;
        end
        if (fall_ready)
        begin
            shift_out_next       = so_new;
            shift_in_next        = {si_base[6:0], 1'b0};
            port_drive[DATA_BIT] = si_base[7];
            if (bc_dec != BIT_COUNT_ZERO)
            begin
                bit_count_next = bc_dec;
            end
            else if (end_hit)
            begin
                bit_count_next = BIT_COUNT_ZERO;
            end
            else
            begin
                bit_count_next = BITS_PER_BYTE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LINK_STOP;
            bit_count_reg <= BIT_COUNT_ZERO;
            shift_out_reg <= 8'h00;
            shift_in_reg  <= 8'h00;
            enabled_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_count_reg <= bit_count_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            enabled_reg   <= enabled_next;
        end
    end

    `KDSL_ASSERT_IMPL(a_ready_count, clk, rst_n, state_reg == LINK_READY, bit_count_reg != BIT_COUNT_ZERO)
    `KDSL_ASSERT_NEXT(a_enable_sticky, clk, rst_n, enabled_reg, enabled_reg)
    `KDSL_ASSERT_IMPL(a_live_enabled, clk, rst_n, state_reg != LINK_STOP, enabled_reg)

endmodule

/* rtl/keyboard_dongle_serial_link_unit.sv */
// Top level of the keyboard dongle serial link: handshakes, config, output word.
// Depends on kdsl_pkg, kdsl_queue and kdsl_link.
//
//   port   | signals                                   | handshake
//   -------+-------------------------------------------+---------------------
//   in     | req_type key_release key_mapped scan_code | in_valid / in_ready
//          | port_prev port_curr                       |
//   out    | port_out keyboard_enabled                 | out_valid / out_ready
//   cfg    | cfg_index cfg_data                        | cfg_we, no wait
//
// Every word is processed in the cycle it is accepted and its result sits in
// the output register on the next cycle; one word per cycle unless stalled.
// The queue head is prefetched from the banked RAM each cycle at the next
// read index, with forwarding of same-cycle writes, so a pop never waits.
// Reset clears control state and indices; the queue RAM holds no reset value.
// A stalled output holds its word and blocks input only while it is full.
module keyboard_dongle_serial_link_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic                                key_release,
    input  logic                                key_mapped,
    input  logic [7:0]                          scan_code,
    input  logic [7:0]                          port_prev,
    input  logic [7:0]                          port_curr,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          port_out,
    output logic                                keyboard_enabled,
    input  logic                                cfg_we,
    input  logic [kdsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kdsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kdsl_pkg::*;

    logic        accept;
    logic        out_valid_reg;
    logic [7:0]  port_out_reg;
    logic        enabled_out_reg;
    logic        bypass_reg;
    logic [7:0]  end_byte_reg;

    key_req_t    key_req;
    q_status_t   q_status;
    logic        load_en;
    logic [7:0]  port_drive;
    logic        enabled_next;

    // Take a new word whenever the output register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign key_req.valid       = accept && !req_type;
    assign key_req.release_key = key_release;
    assign key_req.mapped      = key_mapped;
    assign key_req.code        = scan_code;

    kdsl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_req (key_req),
        .load_en (load_en),
        .status  (q_status)
    );

    kdsl_link u_link (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_en    (accept && req_type),
        .bypass       (bypass_reg),
        .end_byte     (end_byte_reg),
        .port_prev    (port_prev),
        .port_curr    (port_curr),
        .q_status     (q_status),
        .load_en      (load_en),
        .port_drive   (port_drive),
        .enabled_next (enabled_next)
    );

    // Configuration registers: must be written only while the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg   <= 1'b0;
            end_byte_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BYPASS:   bypass_reg   <= cfg_data[0];
                REG_END_BYTE: end_byte_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Output word: key events report a zero port value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            port_out_reg    <= req_type ? port_drive : 8'h00;
            enabled_out_reg <= enabled_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign port_out         = port_out_reg;
    assign keyboard_enabled = enabled_out_reg;

endmodule

/* tb/keyboard_dongle_serial_link_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for keyboard_dongle_serial_link_unit: directed words, then random
// key events and pin-sample sessions, checked against an in-bench model of the link.
// Depends on kdsl_pkg and the block's RTL only.
module keyboard_dongle_serial_link_unit_test;
    import kdsl_pkg::*;

    // One input word and one result word, field by field.
    typedef struct packed {
        logic       req_type;
        logic       key_release;
        logic       key_mapped;
        logic [7:0] scan_code;
        logic [7:0] port_prev;
        logic [7:0] port_curr;
    } word_t;

    typedef struct packed {
        logic [7:0] port_out;
        logic       enabled;
    } res_t;

    // Opening row: the word, and a typed-in result where one is given.
    typedef struct packed {
        word_t w;
        logic  fixed;
        res_t  res;
    } open_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic key_release = 1'b0;
    logic key_mapped = 1'b0;
    logic [7:0] scan_code = 8'h00;
    logic [7:0] port_prev = 8'h00;
    logic [7:0] port_curr = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] port_out;
    logic keyboard_enabled;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BYPASS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    keyboard_dongle_serial_link_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .key_release      (key_release),
        .key_mapped       (key_mapped),
        .scan_code        (scan_code),
        .port_prev        (port_prev),
        .port_curr        (port_curr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .port_out         (port_out),
        .keyboard_enabled (keyboard_enabled),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Link model: own copy of the registers and the state
    // ------------------------------------------------------------------
    logic              bypass_cfg = 1'b0;
    logic [7:0]        end_cfg = 8'h00;
    link_state_t       lk_state = LINK_STOP;
    logic [3:0]        lk_bits = BIT_COUNT_ZERO;
    logic [7:0]        host_byte = 8'h00;    // gathered from the latch pin
    logic [7:0]        dongle_byte = 8'h00;  // sent out on the data pin
    logic [7:0]        scan_fifo [QUEUE_DEPTH];
    logic [IDX_W-1:0]  fifo_wr = IDX_ZERO;
    logic [IDX_W-1:0]  fifo_rd = IDX_ZERO;
    logic              kb_enabled = 1'b0;

    res_t pending_results [$];
    int   bad_results = 0;
    bit   steady_tail = 1'b0;

    // Stimulus shaping state
    logic [7:0] last_pins = 8'h00;
    logic [7:0] latch_plan = 8'h00;
    int         typing_run = 0;
    int         ready_run = 0;

    // Directed opening: key corner cases, start detection, then a full session
    // whose eight latch-low bits match an end byte of zero and drop back to stop.
    open_row_t opening_rows [25] = '{
        // press of an unmapped key with junk on the pin fields
        {1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
        // release of an unmapped key: only the break prefix is queued
        {1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        {1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        {1'b0, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        // stop: clock and latch both high is not a start, key fields ignored
        {1'b1, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h0C, 1'b1, 8'h0C, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h0C, 8'h00, 1'b1, 8'h00, 1'b0},
        // latch high, clock low: start, keyboard enabled
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h04, 1'b1, 8'h04, 1'b1},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h04, 8'hFF, 1'b1, 8'hFF, 1'b1},
        // clock high, latch low: ready
        {1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h08, 1'b1, 8'h08, 1'b1},
        // first falling edge loads the queue head
        {1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b0, 1'b0, 1'b1, 8'h81, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'hF3, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'hF3, 8'h0C, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h0C, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'hF3, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 8'hF3, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'h00, 1'b0, 8'h00, 1'b0},
        // eighth edge: outgoing byte equals the end byte
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h08, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'h04, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h04, 8'h08, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h08, 8'h04, 1'b0, 8'h00, 1'b0},
        {1'b0, 1'b1, 1'b1, 8'h7E, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        {1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h0C, 1'b0, 8'h00, 1'b0}
    };

    // Append one code to the scan queue; drop it once the queue is full.
    task automatic push_code(input logic [7:0] code);
        if (fifo_wr < DEPTH_IDX) begin
            scan_fifo[fifo_wr[ADDR_W-1:0]] = code;
            fifo_wr = fifo_wr + IDX_W'(1);
        end
    endtask

    // Advance the link model by one word and work out its result.
    task automatic model_word(input word_t w, output res_t r);
        logic [7:0] pins;
        pins = 8'h00;
        if (!w.req_type) begin
            // empty queue: rewind both indices before queueing
            if (fifo_wr == fifo_rd) begin
                fifo_wr = IDX_ZERO;
                fifo_rd = IDX_ZERO;
            end
            if (w.key_release && fifo_wr < ROOM_BREAK)
                push_code(CODE_BREAK);
            if (fifo_wr <= ROOM_POP && w.key_mapped)
                push_code(w.scan_code);
        end else begin
            pins = w.port_curr;
            if (!bypass_cfg) begin
                case (lk_state)
                    LINK_STOP: begin
                        if ((pins & PIN_MASK) == PINS_START) begin
                            lk_state = LINK_START;
                            kb_enabled = 1'b1;
                        end
                    end
                    LINK_START: begin
                        if ((pins & PIN_MASK) == PINS_READY) begin
                            lk_state = LINK_READY;
                            lk_bits = BITS_PER_BYTE;
                        end
                    end
                    LINK_READY: begin
                        if (w.port_prev[CLK_BIT] && !pins[CLK_BIT]) begin
                            if (lk_bits == BITS_PER_BYTE) begin
                                // byte boundary: fetch the next queued code
                                host_byte = 8'h00;
                                if (fifo_wr == fifo_rd) begin
                                    dongle_byte = 8'h00;
                                end else if (fifo_wr < ROOM_POP) begin
                                    dongle_byte = scan_fifo[fifo_rd[ADDR_W-1:0]];
                                    fifo_rd = fifo_rd + IDX_W'(1);
                                    if (fifo_wr == fifo_rd) begin
                                        fifo_wr = IDX_ZERO;
                                        fifo_rd = IDX_ZERO;
                                    end
                                end else begin
                                    // overfull at pop time: flush, hold the old byte
                                    fifo_wr = IDX_ZERO;
                                    fifo_rd = IDX_ZERO;
                                end
                            end
                            host_byte = {host_byte[6:0], pins[LATCH_BIT]};
                            pins[DATA_BIT] = dongle_byte[7];
                            dongle_byte = {dongle_byte[6:0], 1'b0};
                            lk_bits = lk_bits - 4'd1;
                            if (lk_bits == BIT_COUNT_ZERO) begin
                                if (host_byte == end_cfg)
                                    lk_state = LINK_STOP;
                                else
                                    lk_bits = BITS_PER_BYTE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.port_out = pins;
        r.enabled = kb_enabled;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Draw the next random word. Most pin samples follow the link state so that
    // sessions start, clock bytes through and end; the rest is noise and keys.
    task automatic pick_word(output word_t w);
        logic [31:0] r0;
        logic [31:0] r1;
        int roll;
        r0 = $urandom;
        r1 = $urandom;
        roll = $urandom_range(0, 99);
        w.req_type = r0[0];
        w.key_release = r0[1];
        w.key_mapped = r0[2];
        w.scan_code = r0[10:3];
        w.port_prev = r0[18:11];
        w.port_curr = r0[26:19];
        if (roll < 8 && typing_run == 0) begin
            // noise: every field as drawn
            if (w.req_type)
                last_pins = w.port_curr;
        end else if (typing_run > 0 || roll < 33) begin
            w.req_type = 1'b0;
            w.key_mapped = (r1[3:0] != 4'h0);
            if (typing_run > 0)
                typing_run--;
            else if (r1[9:4] == 6'd0)
                typing_run = 8 + int'(r1[13:10]);   // burst to fill the queue
        end else begin
            w.req_type = 1'b1;
            if (r1[5:0] != 6'd0)
                w.port_prev = last_pins;
            case (lk_state)
                LINK_STOP:  if (roll < 75) w.port_curr[3:2] = 2'b01;
                LINK_START: if (roll < 75) w.port_curr[3:2] = 2'b10;
                LINK_READY: begin
                    if (w.port_prev[CLK_BIT]) begin
                        // falling edge: the latch carries the planned byte, MSB first
                        if (lk_bits == BITS_PER_BYTE)
                            latch_plan = (r1[7:6] == 2'd0) ? end_cfg : r1[31:24];
                        w.port_curr[CLK_BIT] = 1'b0;
                        w.port_curr[LATCH_BIT] = latch_plan[3'(lk_bits - 4'd1)];
                    end else begin
                        w.port_curr[CLK_BIT] = 1'b1;
                    end
                end
                default: ;
            endcase
            last_pins = w.port_curr;
        end
    endtask

    // Present one word, hold it until taken, then log its expected result.
    task automatic offer_word(input word_t w, input logic fixed, input res_t typed);
        res_t want;
        in_valid <= 1'b1;
        req_type <= w.req_type;
        key_release <= w.key_release;
        key_mapped <= w.key_mapped;
        scan_code <= w.scan_code;
        port_prev <= w.port_prev;
        port_curr <= w.port_curr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_word(w, want);
        pending_results.push_back(fixed ? typed : want);
        // random idle burst after the word, none in the steady tail
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        end
    endtask

    // Write one register while the link is idle and mirror it in the model.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BYPASS)
            bypass_cfg = data[0];
        else
            end_cfg = data;
        @(posedge clk);
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, steady acceptance in the tail
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (steady_tail) begin
            out_ready <= 1'b1;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            ready_run = $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
            ready_run = $urandom_range(0, 14);
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result at %0t: port_out %02h keyboard_enabled %0b",
                             $time, port_out, keyboard_enabled);
            end else begin
                want = pending_results.pop_front();
                if (port_out !== want.port_out || keyboard_enabled !== want.enabled) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch at %0t: port_out exp %02h got %02h, %s %0b got %0b",
                                 $time, want.port_out, port_out, "keyboard_enabled exp",
                                 want.enabled, keyboard_enabled);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        word_t w;
        logic [7:0] end_pick;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening rows with the end byte at its lowest value
        write_reg(REG_BYPASS, 8'h00);
        write_reg(REG_END_BYTE, 8'h00);
        foreach (opening_rows[i])
            offer_word(opening_rows[i].w, opening_rows[i].fixed, opening_rows[i].res);

        // random phases: top end byte, bypass, bottom end byte, then random ones;
        // the last phase runs without idling on either side
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            end_pick = $urandom_range(0, 255);
            case (ph)
                0: end_pick = 8'hFF;
                1: end_pick = 8'h5A;
                2: end_pick = 8'h00;
                default: ;
            endcase
            write_reg(REG_BYPASS, (ph == 1) ? 8'h01 : 8'h00);
            write_reg(REG_END_BYTE, end_pick);
            steady_tail = (ph == 5);
            for (int n = 0; n < 115; n++) begin
                pick_word(w);
                offer_word(w, 1'b0, '0);
            end
        end

        drain_results();
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        if (bad_results == 0 && pending_results.size() == 0)
            $display("keyboard_dongle_serial_link_unit_test: PASS");
        else
            $display("keyboard_dongle_serial_link_unit_test: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("keyboard_dongle_serial_link_unit_test: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/kdsl_pkg.sv
rtl/kdsl_ram.sv
rtl/kdsl_queue.sv
rtl/kdsl_link.sv
rtl/keyboard_dongle_serial_link_unit.sv
tb/keyboard_dongle_serial_link_unit_test.sv
